FILE: design/jeo_pkg.sv
// Package for the Josephus elimination order unit.
// Shared constants, controller state type and command/status structs.
// No dependencies.
package jeo_pkg;

    localparam int MAX_PEOPLE_DEF  = 64;
    localparam int COUNT_WIDTH_DEF = 16;

    // Fixed field widths of the stream payloads
    localparam int PERSON_W = 7;
    localparam int STEP_W   = 16;
    localparam int S_DATA_W = 24;   // person_count + step_count, byte padded
    localparam int M_DATA_W = 8;    // person_number, byte padded

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ERR,
        ST_DIV,
        ST_WALK,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic load;       // take a new request into the datapath
        logic walk_init;  // load the move count from the remainder
        logic walk_step;  // advance one ring slot
        logic emit;       // remove the current person and present it
        logic emit_err;   // present the error result
    } jeo_cmd_t;

    typedef struct packed {
        logic bad_in;     // request at the input has a zero count or step
        logic div_done;   // remainder is ready
        logic walk_done;  // ring position stands on the person to remove
        logic out_free;   // output register can take a result this cycle
        logic final_one;  // one person left in the ring
    } jeo_status_t;

endpackage

FILE: design/josephus_elimination_order_unit.sv
// Josephus elimination order unit, top level.
// Depends on jeo_pkg, jeo_ctrl and jeo_datapath.
//
// Usage:
//   Slave stream (s_): one request per transfer; s_tdata carries
//   person_count n and step_count m. The unit takes one request at a time
//   and raises s_tready again once the last result has entered the output
//   register.
//   Master stream (m_): one transfer per removed person, person number in
//   m_tdata, m_tlast on the final one, m_tuser set for a bad request
//   (n or m zero), which gives a single result with person number 0.
//   Sequence: each removal runs a bit-serial remainder over COUNT_WIDTH
//   dividend bits (capped at 16), a setup step, a walk of one ring slot
//   at a time (at most n slots), a step to stop the walk and a step to
//   issue the result. A bad request goes straight to its error result.
//   The output register holds a result while m_tready is low; the unit
//   keeps working on the next removal and waits only when it has another
//   result ready. Reset is synchronous on aresetn, clears the controller
//   and the output valid; no clearing pass is needed.
module josephus_elimination_order_unit #(
    parameter int MAX_PEOPLE  = jeo_pkg::MAX_PEOPLE_DEF,
    parameter int COUNT_WIDTH = jeo_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [jeo_pkg::S_DATA_W-1:0] s_tdata,  // [6:0] person_count, [22:7] step_count
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [jeo_pkg::M_DATA_W-1:0] m_tdata,  // [6:0] person_number
    output logic                         m_tlast,  // last_of_run
    output logic                         m_tuser   // [0] bad_request
);

    jeo_pkg::jeo_cmd_t    cmd;
    jeo_pkg::jeo_status_t stat;

    jeo_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    jeo_datapath #(
        .MAX_PEOPLE  (MAX_PEOPLE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cmd      (cmd),
        .stat     (stat)
    );

    // a result is only issued when the output register can take it
    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit || cmd.emit_err) |-> stat.out_free)
        else $error("result issued into a full output register");

    // the walker never steps once it stands on the person to remove
    a_walk_stop: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.walk_step |-> !stat.walk_done)
        else $error("ring walk overran");

    // a bad request blocks the input until its error result is out
    a_bad_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && stat.bad_in) |=> !s_tready)
        else $error("input reopened before error result");

    // the final removal returns the unit to idle
    a_final_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.emit && stat.final_one) |=> (s_tready && m_tvalid && m_tlast))
        else $error("final removal did not close the request");

endmodule

FILE: design/jeo_ctrl.sv
// Controller state machine for the Josephus elimination order unit.
// Depends on jeo_pkg; drives the datapath through jeo_cmd_t only.
module jeo_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  jeo_pkg::jeo_status_t stat,
    output jeo_pkg::jeo_cmd_t    cmd
);

    jeo_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= jeo_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            jeo_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (stat.bad_in) begin
                        state_next = jeo_pkg::ST_ERR;
                    end else begin
                        cmd.load   = 1'b1;
                        state_next = jeo_pkg::ST_DIV;
                    end
                end
            end
            jeo_pkg::ST_ERR: begin
                if (stat.out_free) begin
                    cmd.emit_err = 1'b1;
                    state_next   = jeo_pkg::ST_IDLE;
                end
            end
            jeo_pkg::ST_DIV: begin
                if (stat.div_done) begin
                    cmd.walk_init = 1'b1;
                    state_next    = jeo_pkg::ST_WALK;
                end
            end
            jeo_pkg::ST_WALK: begin
                if (stat.walk_done) begin
                    state_next = jeo_pkg::ST_EMIT;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            jeo_pkg::ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = stat.final_one ? jeo_pkg::ST_IDLE : jeo_pkg::ST_DIV;
                end
            end
            default: begin
                state_next = jeo_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/jeo_datapath.sv
// Datapath of the Josephus elimination order unit: ring mask, bit-serial
// remainder unit, ring walker and output register. Depends on jeo_pkg.
module jeo_datapath #(
    parameter int MAX_PEOPLE  = jeo_pkg::MAX_PEOPLE_DEF,
    parameter int COUNT_WIDTH = jeo_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [jeo_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [jeo_pkg::M_DATA_W-1:0]  m_tdata,
    output logic                          m_tlast,
    output logic                          m_tuser,
    input  jeo_pkg::jeo_cmd_t             cmd,
    output jeo_pkg::jeo_status_t          stat
);

    localparam int LEFT_W = $clog2(MAX_PEOPLE + 1);
    localparam int POS_W  = (MAX_PEOPLE > 1) ? $clog2(MAX_PEOPLE) : 1;
    localparam int MW     = (COUNT_WIDTH < jeo_pkg::STEP_W) ? COUNT_WIDTH : jeo_pkg::STEP_W;
    localparam int CNT_W  = $clog2(MW + 1);

    // Input fields
    logic [jeo_pkg::PERSON_W-1:0] n_in;
    logic [MW-1:0]                m_in;
    logic [LEFT_W-1:0]            n_sat;

    assign n_in  = s_tdata[jeo_pkg::PERSON_W-1:0];
    assign m_in  = s_tdata[jeo_pkg::PERSON_W +: MW];
    assign n_sat = (n_in > jeo_pkg::PERSON_W'(MAX_PEOPLE)) ? LEFT_W'(MAX_PEOPLE)
                                                           : LEFT_W'(n_in);

    logic [MAX_PEOPLE-1:0] alive_reg;
    logic [POS_W-1:0]      pos_reg;
    logic [LEFT_W-1:0]     ring_size_reg;
    logic [LEFT_W-1:0]     left_reg;
    logic [LEFT_W-1:0]     moves_reg;
    logic [MW-1:0]         step_reg;
    logic                  first_reg;

    // Remainder unit: (m - 1) mod left, one dividend bit per cycle
    logic [LEFT_W-1:0] div_rem_reg;
    logic [MW-1:0]     div_dvd_reg;
    logic [CNT_W-1:0]  div_cnt_reg;
    logic [LEFT_W:0]   div_trial;
    logic              div_start;

    assign div_trial = {div_rem_reg, div_dvd_reg[MW-1]};
    assign div_start = cmd.load | cmd.emit;

    // Output register
    logic                         m_tvalid_reg;
    logic [jeo_pkg::PERSON_W-1:0] out_person_reg;
    logic                         out_last_reg;
    logic                         out_bad_reg;

    logic [POS_W-1:0] pos_step;
    assign pos_step = (LEFT_W'(pos_reg) == ring_size_reg - LEFT_W'(1)) ?
                      '0 : POS_W'(pos_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_cnt_reg  <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (div_start) begin
                div_cnt_reg <= CNT_W'(MW);
            end else if (div_cnt_reg != '0) begin
                div_cnt_reg <= div_cnt_reg - 1'b1;
            end
            if (cmd.emit || cmd.emit_err) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            for (int i = 0; i < MAX_PEOPLE; i++) begin
                alive_reg[i] <= (i < int'(n_sat));
            end
            pos_reg       <= '0;
            ring_size_reg <= n_sat;
            left_reg      <= n_sat;
            step_reg      <= m_in;
            first_reg     <= 1'b1;
        end
        if (cmd.walk_init) begin
            // after a removal the walk first moves on to the next living person
            moves_reg <= div_rem_reg + (first_reg ? LEFT_W'(0) : LEFT_W'(1));
        end
        if (cmd.walk_step) begin
            pos_reg <= pos_step;
            if (alive_reg[pos_step]) begin
                moves_reg <= moves_reg - 1'b1;
            end
        end
        if (cmd.emit) begin
            alive_reg[pos_reg] <= 1'b0;
            left_reg           <= left_reg - 1'b1;
            first_reg          <= 1'b0;
            out_person_reg     <= jeo_pkg::PERSON_W'(pos_reg) + 1'b1;
            out_last_reg       <= (left_reg == LEFT_W'(1));
            out_bad_reg        <= 1'b0;
        end
        if (cmd.emit_err) begin
            out_person_reg <= '0;
            out_last_reg   <= 1'b1;
            out_bad_reg    <= 1'b1;
        end
        // divider: the dividend is taken from the input on load, from the
        // stored step otherwise; the divisor is left_reg as updated
        if (div_start) begin
            div_rem_reg <= '0;
            div_dvd_reg <= cmd.load ? (m_in - 1'b1) : (step_reg - 1'b1);
        end else if (div_cnt_reg != '0) begin
            if (div_trial >= {1'b0, left_reg}) begin
                div_rem_reg <= LEFT_W'(div_trial - {1'b0, left_reg});
            end else begin
                div_rem_reg <= LEFT_W'(div_trial);
            end
            div_dvd_reg <= div_dvd_reg << 1;
        end
    end

    assign stat.bad_in    = (n_in == '0) || (m_in == '0);
    assign stat.div_done  = (div_cnt_reg == '0);
    assign stat.walk_done = (moves_reg == '0);
    assign stat.out_free  = !m_tvalid_reg || m_tready;
    assign stat.final_one = (left_reg == LEFT_W'(1));

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = jeo_pkg::M_DATA_W'(out_person_reg);
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_bad_reg;

endmodule

FILE: tb/tb_josephus_elimination_order_unit.sv
// Testbench for josephus_elimination_order_unit: directed table then random requests,
// each removal order predicted in the bench and checked transfer by transfer.
// Depends on jeo_pkg and the unit's RTL.
`timescale 1ns / 1ps

module tb_josephus_elimination_order_unit;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 120;
    localparam int QUIET_ITEMS    = 25;
    localparam int RING_SLOTS     = 64;

    typedef struct packed {
        logic [jeo_pkg::PERSON_W-1:0] person;
        logic                         is_last;
        logic                         is_bad;
    } removal_t;

    typedef struct {
        logic [jeo_pkg::PERSON_W-1:0] n;
        logic [jeo_pkg::STEP_W-1:0]   m;
        bit                           typed;
        logic [jeo_pkg::PERSON_W-1:0] person;
        logic                         is_bad;
    } stim_row_t;

    logic                         aclk     = 1'b0;
    logic                         aresetn  = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [jeo_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [jeo_pkg::M_DATA_W-1:0] m_tdata;
    logic                         m_tlast;
    logic                         m_tuser;

    removal_t removal_q[$];
    int       mismatches   = 0;
    int       idle_cycles  = 0;
    bit       quiet        = 1'b0;
    int       rdy_hold     = 0;

    // bench copy of the ring
    logic [RING_SLOTS-1:0]        ring_alive = '0;
    logic [5:0]                   ring_pos   = '0;
    logic [jeo_pkg::STEP_W-1:0]   ring_step  = '0;
    logic [jeo_pkg::PERSON_W-1:0] ring_left  = '0;

    always #5 aclk = ~aclk;

    josephus_elimination_order_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    function automatic logic [5:0] next_living(logic [5:0] p);
        for (int i = 0; i < RING_SLOTS; i++) begin
            p = p + 6'd1;
            if (ring_alive[p]) return p;
        end
        return p;
    endfunction

    function automatic void predict_removal_order(logic [jeo_pkg::PERSON_W-1:0] n_raw,
                                                  logic [jeo_pkg::STEP_W-1:0] m_raw);
        logic [jeo_pkg::PERSON_W-1:0] n;
        int unsigned                  skip;
        removal_t                     r;
        if (n_raw == 0 || m_raw == 0) begin
            r = '{person: '0, is_last: 1'b1, is_bad: 1'b1};
            removal_q.push_back(r);
            return;
        end
        n = (n_raw > jeo_pkg::MAX_PEOPLE_DEF) ? jeo_pkg::PERSON_W'(jeo_pkg::MAX_PEOPLE_DEF)
                                              : n_raw;
        ring_alive = (n >= RING_SLOTS) ? '1 : ((64'd1 << n) - 64'd1);
        ring_pos   = '0;
        ring_step  = m_raw;
        ring_left  = n;
        while (ring_left > 0) begin
            skip = (int'(ring_step) - 1) % int'(ring_left);
            for (int k = 0; k < skip; k++) ring_pos = next_living(ring_pos);
            ring_alive[ring_pos] = 1'b0;
            ring_left = ring_left - 1'b1;
            r = '{person: jeo_pkg::PERSON_W'(ring_pos) + 1'b1,
                  is_last: (ring_left == 0), is_bad: 1'b0};
            removal_q.push_back(r);
            if (ring_left > 0) ring_pos = next_living(ring_pos);
        end
    endfunction

    task automatic report(string what, removal_t want, removal_t got);
        $display("[%0t] %s: expected person %0d last %0b bad %0b, got person %0d last %0b bad %0b",
                 $realtime, what, want.person, want.is_last, want.is_bad,
                 got.person, got.is_last, got.is_bad);
        mismatches++;
    endtask

    // one request transfer; s_tvalid stays high unless a gap is taken
    task automatic send_request(logic [jeo_pkg::PERSON_W-1:0] n,
                                logic [jeo_pkg::STEP_W-1:0] m);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, m, n};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // receiver back-pressure
    always @(posedge aclk) begin
        if (quiet) begin
            m_tready <= 1'b1;
        end else if (rdy_hold > 0) begin
            rdy_hold <= rdy_hold - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rdy_hold <= $urandom_range(0, 15);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // result checker and watchdog
    always @(posedge aclk) begin
        removal_t got;
        removal_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{person: m_tdata[jeo_pkg::PERSON_W-1:0], is_last: m_tlast, is_bad: m_tuser};
            if (removal_q.size() == 0) begin
                report("unexpected result", '0, got);
            end else begin
                want = removal_q.pop_front();
                if (m_tdata != {{(jeo_pkg::M_DATA_W-jeo_pkg::PERSON_W){1'b0}}, want.person})
                    report("person_number", want, got);
                if (m_tlast != want.is_last) report("last_of_run", want, got);
                if (m_tuser != want.is_bad) report("bad_request", want, got);
            end
        end
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles", $realtime, idle_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        stim_row_t                    rows[$];
        logic [jeo_pkg::PERSON_W-1:0] n;
        logic [jeo_pkg::STEP_W-1:0]   m;
        int                           sel;
        removal_t                     r;

        rows = '{
            '{n: 0,   m: 5,     typed: 1, person: 0, is_bad: 1},
            '{n: 5,   m: 0,     typed: 1, person: 0, is_bad: 1},
            '{n: 0,   m: 0,     typed: 1, person: 0, is_bad: 1},
            '{n: 0,   m: 65535, typed: 1, person: 0, is_bad: 1},
            '{n: 127, m: 0,     typed: 1, person: 0, is_bad: 1},
            '{n: 1,   m: 1,     typed: 1, person: 1, is_bad: 0},
            '{n: 1,   m: 65535, typed: 1, person: 1, is_bad: 0},
            '{n: 7,   m: 3,     typed: 0, person: 0, is_bad: 0},
            '{n: 2,   m: 2,     typed: 0, person: 0, is_bad: 0},
            '{n: 5,   m: 1,     typed: 0, person: 0, is_bad: 0},
            '{n: 64,  m: 1,     typed: 0, person: 0, is_bad: 0},
            '{n: 64,  m: 65535, typed: 0, person: 0, is_bad: 0},
            '{n: 64,  m: 64,    typed: 0, person: 0, is_bad: 0},
            '{n: 65,  m: 3,     typed: 0, person: 0, is_bad: 0},
            '{n: 127, m: 2,     typed: 0, person: 0, is_bad: 0},
            '{n: 3,   m: 65534, typed: 0, person: 0, is_bad: 0},
            '{n: 10,  m: 10,    typed: 0, person: 0, is_bad: 0},
            '{n: 41,  m: 3,     typed: 0, person: 0, is_bad: 0},
            '{n: 100, m: 16'hAAAA, typed: 0, person: 0, is_bad: 0},
            '{n: 16,  m: 16'h5555, typed: 0, person: 0, is_bad: 0},
            '{n: 63,  m: 32768, typed: 0, person: 0, is_bad: 0}
        };

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) begin
            if (rows[i].typed) begin
                r = '{person: rows[i].person, is_last: 1'b1, is_bad: rows[i].is_bad};
                removal_q.push_back(r);
            end else begin
                predict_removal_order(rows[i].n, rows[i].m);
            end
            send_request(rows[i].n, rows[i].m);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS - QUIET_ITEMS) quiet = 1'b1;
            sel = $urandom_range(0, 19);
            if (sel == 0) begin
                n = '0;
                m = jeo_pkg::STEP_W'($urandom);
            end else if (sel == 1) begin
                n = jeo_pkg::PERSON_W'($urandom_range(0, 127));
                m = '0;
            end else begin
                n = (sel == 2) ? jeo_pkg::PERSON_W'($urandom_range(33, 127))
                               : jeo_pkg::PERSON_W'($urandom_range(1, 24));
                m = ($urandom_range(0, 3) == 0) ? jeo_pkg::STEP_W'($urandom)
                                                : jeo_pkg::STEP_W'($urandom_range(1, 2 * n + 2));
            end
            predict_removal_order(n, m);
            send_request(n, m);
        end
        s_tvalid <= 1'b0;

        while (removal_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);

        if (mismatches == 0 && removal_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

FILE: files.f
design/jeo_pkg.sv
design/jeo_ctrl.sv
design/jeo_datapath.sv
design/josephus_elimination_order_unit.sv
tb/tb_josephus_elimination_order_unit.sv
